FILE: sv/lru_keyed_result_cache_assert.svh
// ----------------------------------------------------------------------------
// LRU keyed result cache assertion macros
// Concurrent property wrappers shared by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_RESULT_CACHE_ASSERT_SVH
`define LRU_KEYED_RESULT_CACHE_ASSERT_SVH

// same-cycle implication
`define LKRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkrc assertion failed");

// next-cycle implication
`define LKRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkrc assertion failed");

`endif

FILE: sv/lkrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU keyed result cache package
// Shared sizes, operation codes and control structs.
// ----------------------------------------------------------------------------
package lkrc_pkg;

    localparam int CAPACITY    = 16;
    localparam int KEY_WIDTH   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int LIMIT_W     = 5;
    localparam int MODE_W      = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef struct packed {
        logic              start;
        logic              take;
        logic [MODE_W-1:0] mode;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic done;
        logic hit;
    } t_eng_stat;

endpackage

FILE: sv/lkrc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU keyed result cache RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lkrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lkrc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU keyed result cache engine
// Search pass and read-modify-write recency pass over the entry memory.
// ----------------------------------------------------------------------------
module lkrc_engine #(
    parameter int CAPACITY    = lkrc_pkg::CAPACITY,
    parameter int KEY_WIDTH   = lkrc_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkrc_pkg::VALUE_WIDTH,
    localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkrc_pkg::t_eng_ctl           i_ctl,
    input  logic [KEY_WIDTH-1:0]         i_key,
    input  logic [VALUE_WIDTH-1:0]       i_value,
    input  logic [lkrc_pkg::LIMIT_W-1:0] i_limit,
    output lkrc_pkg::t_eng_stat          o_stat,
    output logic [VALUE_WIDTH-1:0]       o_value,
    output logic [CNT_W-1:0]             o_count
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam int RW1    = RANK_W + 1;
    localparam int DW     = KEY_WIDTH + VALUE_WIDTH + RANK_W;
    localparam int EW     = (lkrc_pkg::LIMIT_W > CNT_W) ? lkrc_pkg::LIMIT_W : CNT_W;

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [RANK_W-1:0] OLD_RANK = RANK_W'(CAPACITY - 1);
    localparam logic [IDX_W:0]    CAP_IDX  = (IDX_W + 1)'(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [IDX_W:0]                r_cnt, n_cnt;
    logic                          r_rvld, n_rvld;
    logic [IDX_W-1:0]              r_ridx, n_ridx;
    logic [CAPACITY-1:0]           r_valid, n_valid;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_hit, n_hit;
    logic [lkrc_pkg::MODE_W-1:0]   r_mode, n_mode;
    logic [KEY_WIDTH-1:0]          r_key, n_key;
    logic [VALUE_WIDTH-1:0]        r_val, n_val;
    logic [IDX_W-1:0]              r_slot, n_slot;
    logic [RANK_W-1:0]             r_rank, n_rank;
    logic [VALUE_WIDTH-1:0]        r_hval, n_hval;
    logic                          r_have_free, n_have_free;
    logic [IDX_W-1:0]              r_free, n_free;
    logic [IDX_W-1:0]              r_old, n_old;

    logic                          rd_issue;
    logic [IDX_W-1:0]              mem_raddr;
    logic                          mem_we;
    logic [DW-1:0]                 mem_wdata;
    logic [DW-1:0]                 mem_rdata;
    logic [KEY_WIDTH-1:0]          d_key;
    logic [VALUE_WIDTH-1:0]        d_val;
    logic [RANK_W-1:0]             d_rank;
    logic [KEY_WIDTH-1:0]          w_key;
    logic [VALUE_WIDTH-1:0]        w_val;
    logic [RANK_W-1:0]             w_rank;
    logic                          inc;
    logic [RW1-1:0]                next_rank;
    logic [EW-1:0]                 lim_ext;
    logic [EW-1:0]                 cap_ext;
    logic [CNT_W-1:0]              eff_lim;
    logic [CNT_W-1:0]              base_count;

    lkrc_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ridx),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign d_key  = mem_rdata[DW-1 -: KEY_WIDTH];
    assign d_val  = mem_rdata[RANK_W +: VALUE_WIDTH];
    assign d_rank = mem_rdata[RANK_W-1:0];

    assign lim_ext = EW'(i_limit);
    assign cap_ext = EW'(CAPACITY);

    always_comb begin
        if (lim_ext == '0) begin
            eff_lim = CNT_W'(1);
        end else if (lim_ext > cap_ext) begin
            eff_lim = CNT_W'(CAPACITY);
        end else begin
            eff_lim = CNT_W'(lim_ext);
        end
    end

    assign base_count = r_hit ? r_count :
                        (r_count == CNT_W'(CAPACITY)) ? r_count : r_count + CNT_W'(1);

    assign rd_issue  = ((r_state == ST_SCAN) || (r_state == ST_UPD)) && (r_cnt < CAP_IDX);
    assign mem_raddr = r_cnt[IDX_W-1:0];

    assign inc       = ((r_mode == lkrc_pkg::MODE_INSERT) && !r_hit) || (d_rank < r_rank);
    assign next_rank = RW1'(d_rank) + RW1'(inc);

    always_comb begin
        if (r_ridx == r_slot) begin
            w_key  = r_key;
            w_val  = (r_mode == lkrc_pkg::MODE_FIND) ? d_val : r_val;
            w_rank = '0;
        end else begin
            w_key  = d_key;
            w_val  = d_val;
            w_rank = next_rank[RANK_W-1:0];
        end
    end

    assign mem_wdata = {w_key, w_val, w_rank};
    assign mem_we    = (r_state == ST_UPD) && r_rvld;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rvld      = rd_issue;
        n_ridx      = mem_raddr;
        n_valid     = r_valid;
        n_count     = r_count;
        n_hit       = r_hit;
        n_mode      = r_mode;
        n_key       = r_key;
        n_val       = r_val;
        n_slot      = r_slot;
        n_rank      = r_rank;
        n_hval      = r_hval;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_old       = r_old;

        if (rd_issue) begin
            n_cnt = r_cnt + (IDX_W + 1)'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_mode      = i_ctl.mode;
                    n_key       = i_key;
                    n_val       = i_value;
                    n_hit       = 1'b0;
                    n_have_free = 1'b0;
                    n_cnt       = '0;
                    unique case (i_ctl.mode) inside
                        lkrc_pkg::MODE_FIND, lkrc_pkg::MODE_INSERT: begin
                            n_state = ST_SCAN;
                        end
                        lkrc_pkg::MODE_CLEAR: begin
                            n_valid = '0;
                            n_count = '0;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_rvld) begin
                    if (r_valid[r_ridx] && (d_key == r_key) && !r_hit) begin
                        n_hit  = 1'b1;
                        n_slot = r_ridx;
                        n_rank = d_rank;
                        n_hval = d_val;
                    end
                    if (!r_valid[r_ridx] && !r_have_free) begin
                        n_have_free = 1'b1;
                        n_free      = r_ridx;
                    end
                    if (r_valid[r_ridx] && (d_rank == OLD_RANK)) begin
                        n_old = r_ridx;
                    end
                    if (r_ridx == LAST_IDX) begin
                        n_cnt = '0;
                        if ((r_mode == lkrc_pkg::MODE_FIND) && !n_hit) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_UPD;
                            if (!n_hit) begin
                                n_slot = n_have_free ? n_free : n_old;
                            end
                        end
                    end
                end
            end
            ST_UPD: begin
                if (r_rvld) begin
                    if (r_ridx == r_slot) begin
                        n_valid[r_ridx] = 1'b1;
                    end else if (r_valid[r_ridx] && (r_mode == lkrc_pkg::MODE_INSERT) &&
                                 (next_rank >= RW1'(eff_lim))) begin
                        n_valid[r_ridx] = 1'b0;
                    end
                    if (r_ridx == LAST_IDX) begin
                        n_cnt   = '0;
                        n_state = ST_DONE;
                        if (r_mode == lkrc_pkg::MODE_INSERT) begin
                            n_count = (base_count > eff_lim) ? eff_lim : base_count;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rvld  <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rvld  <= n_rvld;
            r_valid <= n_valid;
            r_count <= n_count;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx      <= n_ridx;
        r_mode      <= n_mode;
        r_key       <= n_key;
        r_val       <= n_val;
        r_slot      <= n_slot;
        r_rank      <= n_rank;
        r_hval      <= n_hval;
        r_have_free <= n_have_free;
        r_free      <= n_free;
        r_old       <= n_old;
    end

    assign o_stat.idle = (r_state == ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_stat.hit  = r_hit && (r_mode == lkrc_pkg::MODE_FIND);
    assign o_value     = o_stat.hit ? r_hval : '0;
    assign o_count     = r_count;

endmodule

FILE: sv/lru_keyed_result_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU keyed result cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Requests arrive on the slave stream with the operation in tuser (find,
// insert, clear) and key and value in tdata; each request returns one result
// with the hit flag in tuser and value and occupancy in tdata. Entries live in
// a single-port-read entry memory that an insert or a find hit walks twice,
// once to search and once to rewrite recency ranks; a find miss only searches
// and a clear or unused operation does not walk it. A finished result waits
// in the output register while the next request is taken. The user must write
// the entry limit only while idle; the block does not enforce this. It applies
// at the next insert.
module lru_keyed_result_cache #(
    parameter int CAPACITY    = lkrc_pkg::CAPACITY,
    parameter int KEY_WIDTH   = lkrc_pkg::KEY_WIDTH,
    parameter int VALUE_WIDTH = lkrc_pkg::VALUE_WIDTH,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IN_DW      = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW     = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [lkrc_pkg::LIMIT_W-1:0] i_cfg_wr_data,   // entry_limit
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [IN_DW-1:0]             s_axis_tdata,    // lookup_key, value_in
    input  logic [lkrc_pkg::MODE_W-1:0]  s_axis_tuser,    // mode
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_DW-1:0]            m_axis_tdata,    // value_out, occupancy
    output logic                         m_axis_tuser     // hit
);

    logic [lkrc_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic                         r_m_valid, n_m_valid;
    logic                         r_m_hit;
    logic [VALUE_WIDTH-1:0]       r_m_value;
    logic [CNT_W-1:0]             r_m_occ;

    lkrc_pkg::t_eng_ctl           eng_ctl;
    lkrc_pkg::t_eng_stat          eng_stat;
    logic [VALUE_WIDTH-1:0]       eng_value;
    logic [CNT_W-1:0]             eng_count;
    logic                         w_take;

    assign s_axis_tready = eng_stat.idle;
    assign w_take        = eng_stat.done && (!r_m_valid || m_axis_tready);

    assign eng_ctl.start = s_axis_tvalid && s_axis_tready;
    assign eng_ctl.take  = w_take;
    assign eng_ctl.mode  = s_axis_tuser;

    lkrc_engine #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_key   (s_axis_tdata[KEY_WIDTH-1:0]),
        .i_value (s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH]),
        .i_limit (r_limit),
        .o_stat  (eng_stat),
        .o_value (eng_value),
        .o_count (eng_count)
    );

    always_comb begin
        n_limit = i_cfg_wr_en ? i_cfg_wr_data : r_limit;
        if (w_take) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= lkrc_pkg::LIMIT_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_limit   <= n_limit;
            r_m_valid <= n_m_valid;
        end
    end

    // hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_m_hit   <= eng_stat.hit;
            r_m_value <= eng_value;
            r_m_occ   <= eng_count;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_hit;
    assign m_axis_tdata  = OUT_DW'({r_m_occ, r_m_value});

`include "lru_keyed_result_cache_assert.svh"

    `LKRC_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `LKRC_ASSERT_NXT(a_take_loads, i_clk, i_rst_n, w_take, m_axis_tvalid)
    `LKRC_ASSERT_IMP(a_occ_range, i_clk, i_rst_n, m_axis_tvalid, r_m_occ <= CNT_W'(CAPACITY))
    `LKRC_ASSERT_IMP(a_hit_occ, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, r_m_occ != '0)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU keyed result cache testbench
// Runs a table of directed requests and then phases of random requests
// against lru_keyed_result_cache. A shadow copy of the cache (keys, values,
// recency ranks, occupancy and entry limit) predicts each result the table
// does not give, and every result is compared field by field with what the
// block returns. Between phases the entry limit is reprogrammed while the
// block is idle; stream sides idle at random in four repeating patterns.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAPACITY    = lkrc_pkg::CAPACITY;
    localparam int KEY_WIDTH   = lkrc_pkg::KEY_WIDTH;
    localparam int VALUE_WIDTH = lkrc_pkg::VALUE_WIDTH;
    localparam int LIMIT_W     = lkrc_pkg::LIMIT_W;
    localparam int MODE_W      = lkrc_pkg::MODE_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = lkrc_pkg::LIMIT_RESET;

    localparam logic [MODE_W-1:0] MODE_FIND   = lkrc_pkg::MODE_FIND;
    localparam logic [MODE_W-1:0] MODE_INSERT = lkrc_pkg::MODE_INSERT;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = lkrc_pkg::MODE_CLEAR;

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IN_DW    = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DW   = ((VALUE_WIDTH + CNT_W + 7) / 8) * 8;
    localparam int POOL     = 20;
    localparam int PHASES   = 8;
    localparam int PER_PHASE = 60;
    localparam int WATCHDOG = 4000;
    localparam int DRAIN    = 2 * CAPACITY + 8;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [KEY_WIDTH-1:0]   KEY_ONES = '1;
    localparam logic [VALUE_WIDTH-1:0] VAL_ONES = '1;
    localparam logic [KEY_WIDTH-1:0]   KEY_A    = 64'h0123_4567_89AB_CDEF;
    localparam logic [KEY_WIDTH-1:0]   KEY_B    = 64'hFEDC_BA98_7654_3210;
    localparam logic [KEY_WIDTH-1:0]   KEY_C    = 64'h8000_0000_0000_0001;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] value;
        logic [CNT_W-1:0]       occ;
    } t_outcome;

    typedef enum logic {ROW_REQUEST, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [MODE_W-1:0]      mode;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
        logic                   typed;
        t_outcome               want;
    } t_row;

    localparam t_outcome NONE = '0;

    t_row directed_rows [25] = '{
        '{ROW_REQUEST, MODE_FIND,   '0,       '0,           1'b1, '{1'b0, '0, 5'd0}},
        '{ROW_REQUEST, MODE_UNUSED, '0,       '0,           1'b1, '{1'b0, '0, 5'd0}},
        '{ROW_REQUEST, MODE_INSERT, '0,       '0,           1'b1, '{1'b0, '0, 5'd1}},
        '{ROW_REQUEST, MODE_INSERT, KEY_ONES, VAL_ONES,     1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   KEY_ONES, '0,           1'b1, '{1'b1, VAL_ONES, 5'd2}},
        '{ROW_REQUEST, MODE_FIND,   '0,       VAL_ONES,     1'b0, NONE},
        '{ROW_REQUEST, MODE_INSERT, '0,       32'h1234_5678, 1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   '0,       '0,           1'b0, NONE},
        '{ROW_REQUEST, MODE_UNUSED, KEY_ONES, VAL_ONES,     1'b1, '{1'b0, '0, 5'd2}},
        '{ROW_REQUEST, MODE_CLEAR,  KEY_ONES, VAL_ONES,     1'b1, '{1'b0, '0, 5'd0}},
        '{ROW_REQUEST, MODE_FIND,   KEY_ONES, '0,           1'b0, NONE},
        '{ROW_LIMIT,   MODE_FIND,   '0,       32'd2,        1'b0, NONE},
        '{ROW_REQUEST, MODE_INSERT, KEY_A,    32'd1,        1'b0, NONE},
        '{ROW_REQUEST, MODE_INSERT, KEY_B,    32'd2,        1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   KEY_A,    '0,           1'b0, NONE},
        '{ROW_REQUEST, MODE_INSERT, KEY_C,    32'd3,        1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   KEY_B,    '0,           1'b0, NONE},
        '{ROW_LIMIT,   MODE_FIND,   '0,       32'd0,        1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   KEY_A,    '0,           1'b0, NONE},
        '{ROW_REQUEST, MODE_INSERT, KEY_C,    32'd4,        1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   KEY_A,    '0,           1'b0, NONE},
        '{ROW_LIMIT,   MODE_FIND,   '0,       32'd31,       1'b0, NONE},
        '{ROW_REQUEST, MODE_INSERT, KEY_A,    32'd5,        1'b0, NONE},
        '{ROW_REQUEST, MODE_FIND,   KEY_C,    '0,           1'b0, NONE},
        '{ROW_LIMIT,   MODE_FIND,   '0,       32'd16,       1'b0, NONE}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]    i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DW-1:0]      s_axis_tdata = '0;
    logic [MODE_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;

    logic                  req_typed = 1'b0;
    t_outcome              req_want = '0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    n_errors = 0;
    int                    quiet_cycles = 0;
    t_outcome              pending_results [$];

    logic                   shadow_valid [CAPACITY];
    logic [KEY_WIDTH-1:0]   shadow_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] shadow_value [CAPACITY];
    int                     shadow_rank  [CAPACITY];
    int                     shadow_count;
    logic [LIMIT_W-1:0]     shadow_limit;

    lru_keyed_result_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // lookup_key, value_in
        .s_axis_tuser  (s_axis_tuser),    // mode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // value_out, occupancy
        .m_axis_tuser  (m_axis_tuser)     // hit
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp_limit(logic [LIMIT_W-1:0] lim);
        if (lim < 1) return 1;
        if (lim > CAPACITY) return CAPACITY;
        return int'(lim);
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < CAPACITY; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
        end
        shadow_count = 0;
    endfunction

    function automatic int slot_of(logic [KEY_WIDTH-1:0] k);
        for (int i = 0; i < CAPACITY; i++) begin
            if (shadow_valid[i] && shadow_key[i] == k) return i;
        end
        return -1;
    endfunction

    function automatic void make_recent(int s);
        int r;
        r = shadow_rank[s];
        for (int i = 0; i < CAPACITY; i++) begin
            if (shadow_valid[i] && i != s && shadow_rank[i] < r) shadow_rank[i]++;
        end
        shadow_rank[s] = 0;
    endfunction

    function automatic void evict_oldest();
        logic gone;
        gone = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (!gone && shadow_count > 0 && shadow_valid[i] &&
                shadow_rank[i] == shadow_count - 1) begin
                shadow_valid[i] = 1'b0;
                shadow_rank[i]  = 0;
                shadow_count--;
                gone = 1'b1;
            end
        end
    endfunction

    function automatic t_outcome cache_outcome(logic [MODE_W-1:0] mode,
                                               logic [KEY_WIDTH-1:0] k,
                                               logic [VALUE_WIDTH-1:0] v);
        t_outcome o;
        int s;
        logic placed;
        o = '0;
        s = slot_of(k);
        case (mode)
            MODE_FIND: begin
                if (s >= 0) begin
                    o.hit   = 1'b1;
                    o.value = shadow_value[s];
                    make_recent(s);
                end
            end
            MODE_INSERT: begin
                if (s >= 0) begin
                    shadow_value[s] = v;
                    make_recent(s);
                end else begin
                    if (shadow_count >= CAPACITY) evict_oldest();
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (shadow_valid[i]) shadow_rank[i]++;
                    end
                    placed = 1'b0;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!placed && !shadow_valid[i]) begin
                            shadow_valid[i] = 1'b1;
                            shadow_key[i]   = k;
                            shadow_value[i] = v;
                            shadow_rank[i]  = 0;
                            shadow_count++;
                            placed = 1'b1;
                        end
                    end
                end
                while (shadow_count > clamp_limit(shadow_limit)) evict_oldest();
            end
            MODE_CLEAR: clear_shadow();
            default: ;
        endcase
        o.occ = shadow_count[CNT_W-1:0];
        return o;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_outcome want;
        t_outcome got;
        logic     busy;
        if (!i_rst_n) begin
            clear_shadow();
            shadow_limit = LIMIT_RESET;
            quiet_cycles = 0;
        end else begin
            busy = 1'b0;
            if (i_cfg_wr_en) begin
                shadow_limit = i_cfg_wr_data;
                busy = 1'b1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = cache_outcome(s_axis_tuser, s_axis_tdata[KEY_WIDTH-1:0],
                                     s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH]);
                pending_results.insert(pending_results.size(), req_typed ? req_want : want);
                busy = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                busy = 1'b1;
                got.hit   = m_axis_tuser;
                got.value = m_axis_tdata[VALUE_WIDTH-1:0];
                got.occ   = m_axis_tdata[VALUE_WIDTH +: CNT_W];
                if (pending_results.size() == 0) begin
                    $error("result with no request pending");
                    n_errors++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.hit !== want.hit) begin
                        $error("hit expected %0d got %0d", want.hit, got.hit);
                        n_errors++;
                    end
                    if (got.value !== want.value) begin
                        $error("value_out expected %h got %h", want.value, got.value);
                        n_errors++;
                    end
                    if (got.occ !== want.occ) begin
                        $error("occupancy expected %0d got %0d", want.occ, got.occ);
                        n_errors++;
                    end
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic send_request(logic [MODE_W-1:0] mode, logic [KEY_WIDTH-1:0] k,
                                logic [VALUE_WIDTH-1:0] v, logic typed, t_outcome want);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = '0;
        s_axis_tdata[KEY_WIDTH-1:0] = k;
        s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH] = v;
        req_typed = typed;
        req_want  = want;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic set_entry_limit(logic [LIMIT_W-1:0] lim);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = lim;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    initial begin
        logic [KEY_WIDTH-1:0] key_pool [POOL];
        logic [KEY_WIDTH-1:0] k;
        logic [MODE_W-1:0]    mode;
        logic [LIMIT_W-1:0]   lim;
        int                   phase_limits [PHASES];
        int                   span;
        int                   pick;

        phase_limits = '{16, 1, 31, 0, 5, 16, 0, 8};
        for (int i = 0; i < POOL; i++) key_pool[i] = {$urandom(), $urandom()};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_LIMIT) begin
                set_entry_limit(directed_rows[r].value[LIMIT_W-1:0]);
            end else begin
                send_request(directed_rows[r].mode, directed_rows[r].key,
                             directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            lim = (ph == 6) ? LIMIT_W'($urandom_range(0, 31)) : LIMIT_W'(phase_limits[ph]);
            set_entry_limit(lim);
            span = (clamp_limit(lim) + 3 > POOL) ? POOL : clamp_limit(lim) + 3;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 44)      mode = MODE_FIND;
                else if (pick < 88) mode = MODE_INSERT;
                else if (pick < 91) mode = MODE_CLEAR;
                else                mode = MODE_UNUSED;
                if ($urandom_range(0, 9) == 0) k = {$urandom(), $urandom()};
                else                           k = key_pool[$urandom_range(0, span - 1)];
                send_request(mode, k, $urandom(), 1'b0, NONE);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/lkrc_pkg.sv
sv/lkrc_ram.sv
sv/lkrc_engine.sv
sv/lru_keyed_result_cache.sv
bench/tb.sv
